FILE: rtl/core/field_frame_omni_wheel_kinematics_defines.svh
// Assertion macros shared by the field-frame omni-wheel kinematics RTL.
`ifndef FIELD_FRAME_OMNI_WHEEL_KINEMATICS_DEFINES_SVH
`define FIELD_FRAME_OMNI_WHEEL_KINEMATICS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFOWK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FFOWK_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/ffowk_pkg.sv
// Package with constants and tables for the field-frame omni-wheel kinematics.
`timescale 1ns / 1ps
package ffowk_pkg;

    localparam int WHEEL_COUNT_DEF  = 4;
    localparam int ANGLE_BITS_DEF   = 16;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int IN_W    = 16;
    localparam int OUT_W   = 18;
    localparam int DEG_W   = 9;
    localparam int HOUT_W  = 16;
    localparam int GUARD   = 8;
    localparam int XW      = 28;
    localparam int ZW      = 34;
    localparam int ACC_W   = 48;
    localparam int GAIN_W  = 20;
    localparam int REM_W   = 15;
    localparam int QUO_W   = 9;
    localparam int CNT_W   = 5;
    localparam int WHL_W   = 2;
    localparam int WHL_MAX = 4;

    localparam logic [GAIN_W-1:0] INV_GAIN   = 20'd636751;
    localparam logic [17:0]       RAD_TO_BAM = 18'd166886;
    localparam logic [23:0]       DEG_K      = 24'd11930464;
    localparam logic [DEG_W-1:0]  DEG_FULL   = 9'd360;
    localparam logic [REM_W-1:0]  DIV_DEN    = 15'd90;
    localparam logic [REM_W-1:0]  DIV_BIAS   = 15'd45;

    // Arctangent of 2^-i in 2^32-per-turn units.
    function automatic logic [29:0] atan_step(input logic [CNT_W-1:0] i);
        logic [29:0] v;
        case (i)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [DEG_W-1:0] reset_angle(input logic [WHL_W-1:0] k);
        logic [DEG_W-1:0] v;
        case (k)
            2'd0:    v = 9'd45;
            2'd1:    v = 9'd135;
            2'd2:    v = 9'd225;
            default: v = 9'd315;
        endcase
        return v;
    endfunction

endpackage

FILE: rtl/core/field_frame_omni_wheel_kinematics.sv
// Top level of the field-frame omni-wheel inverse kinematics block.
// A single shared rotator walks the wheels one after another, and a new command is
// accepted only while the block is idle, so it finishes one command before taking the next.
// Each wheel goes through the divider, a setup step, CORDIC_STEPS rotations, the multiply
// and a sum; the heading update waits while the previous result is still held at the output.
// Synchronous active-low reset clears the heading, restores the angles, empties the output.
`timescale 1ns / 1ps
`include "field_frame_omni_wheel_kinematics_defines.svh"
module field_frame_omni_wheel_kinematics
    import ffowk_pkg::*;
#(
    parameter int WHEEL_COUNT  = WHEEL_COUNT_DEF,
    parameter int ANGLE_BITS   = ANGLE_BITS_DEF,
    parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [WHL_W-1:0]         i_cfg_idx,
    input  logic [DEG_W-1:0]         i_cfg_data,
    input  logic                     i_in_valid,
    output logic                     o_in_ready,
    input  logic signed [IN_W-1:0]   i_vel_x,
    input  logic signed [IN_W-1:0]   i_vel_y,
    input  logic signed [IN_W-1:0]   i_yaw_rate,
    output logic                     o_out_valid,
    input  logic                     i_out_ready,
    output logic signed [OUT_W-1:0]  o_wheel0_speed,
    output logic signed [OUT_W-1:0]  o_wheel1_speed,
    output logic signed [OUT_W-1:0]  o_wheel2_speed,
    output logic signed [OUT_W-1:0]  o_wheel3_speed,
    output logic [HOUT_W-1:0]        o_heading_out
);

    localparam int HSHIFT = 32 - ANGLE_BITS;

    // Per item: wheels are processed one by one. For each wheel the mounting angle
    // is turned into a 32-bit binary angle with a bit-serial restoring divider, the
    // command is rotated by (angle - heading) one CORDIC step per cycle, and the gain
    // is removed with a bit-serial shift-add multiply. The heading is updated last.
    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_PREP, ST_ROT, ST_MUL, ST_SUM, ST_HEAD
    } t_state;

    t_state                    r_state, n_state;
    logic [WHL_W-1:0]          r_wheel, n_wheel;
    logic [CNT_W-1:0]          r_cnt, n_cnt;
    logic signed [IN_W-1:0]    r_vx, n_vx, r_vy, n_vy, r_w, n_w;
    logic [DEG_W-1:0]          r_angle [WHL_MAX];
    logic [DEG_W-1:0]          n_angle [WHL_MAX];
    logic [ANGLE_BITS-1:0]     r_heading, n_heading;
    logic [REM_W-1:0]          r_rem, n_rem;
    logic [QUO_W-1:0]          r_q, n_q;
    logic [DEG_W-1:0]          r_amod, n_amod;
    logic signed [XW-1:0]      r_x, n_x, r_y, n_y;
    logic signed [ZW-1:0]      r_z, n_z;
    logic signed [ACC_W-1:0]   r_acc, n_acc;
    logic signed [OUT_W-1:0]   r_speed [WHL_MAX];
    logic signed [OUT_W-1:0]   n_speed [WHL_MAX];
    logic signed [OUT_W-1:0]   r_ospd [WHL_MAX];
    logic signed [OUT_W-1:0]   n_ospd [WHL_MAX];
    logic [HOUT_W-1:0]         r_hout, n_hout;
    logic                      r_out_valid, n_out_valid;

    // Datapath terms.
    logic [WHL_W-1:0]          s_next_wheel;
    logic [DEG_W-1:0]          s_raw_angle, s_amod;
    logic [REM_W-1:0]          s_div_d;
    logic [31:0]               s_prod_a;
    logic [31:0]               s_a32, s_h32, s_t;
    logic signed [ZW-1:0]      s_z0;
    logic signed [XW-1:0]      s_x0, s_y0, s_xs, s_ys;
    logic signed [ZW-1:0]      s_atan;
    logic signed [ACC_W-1:0]   s_round;
    logic signed [XW:0]        s_v2;
    logic signed [XW:0]        s_v3;
    logic signed [OUT_W-1:0]   s_sat;
    logic signed [34:0]        s_hprod, s_hsum;
    logic [ANGLE_BITS-1:0]     s_heading;
    logic [31:0]               s_hwide;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_wheel0_speed = r_ospd[0];
    assign o_wheel1_speed = r_ospd[1];
    assign o_wheel2_speed = r_ospd[2];
    assign o_wheel3_speed = (WHEEL_COUNT > 3) ? r_ospd[3] : '0;
    assign o_heading_out  = r_hout;

    always_comb begin
        // Angle setup for the wheel that starts next.
        s_next_wheel = (r_state == ST_IDLE) ? '0 : r_wheel + 1'b1;
        s_raw_angle  = r_angle[s_next_wheel];
        s_amod       = (s_raw_angle >= DEG_FULL) ? s_raw_angle - DEG_FULL : s_raw_angle;
        s_div_d      = DIV_DEN << r_cnt;

        // Binary angle of the wheel relative to the current heading.
        s_prod_a = 32'(r_amod) * 32'(DEG_K);
        s_a32    = s_prod_a + 32'(r_q);
        s_h32    = {r_heading, {HSHIFT{1'b0}}};
        s_t      = s_a32 - s_h32;
        s_z0     = ZW'($signed(s_t));
        s_x0     = XW'(r_vx) <<< GUARD;
        s_y0     = XW'(r_vy) <<< GUARD;

        s_xs   = r_x >>> r_cnt;
        s_ys   = r_y >>> r_cnt;
        s_atan = $signed(ZW'(atan_step(r_cnt)));

        // Gain-corrected rotator output plus yaw rate, rounded to Q12 and saturated.
        s_round = (r_acc + (ACC_W'(1) <<< 19)) >>> 20;
        s_v2    = (XW+1)'($signed(s_round[XW-1:0])) + ((XW+1)'(r_w) <<< GUARD);
        s_v3    = (s_v2 + (XW+1)'(128)) >>> GUARD;
        if (s_v3 > (XW+1)'(131071)) begin
            s_sat = 18'sd131071;
        end else if (s_v3 < -(XW+1)'(131072)) begin
            s_sat = -18'sd131072;
        end else begin
            s_sat = s_v3[OUT_W-1:0];
        end

        // Heading advance in binary angle units.
        s_hprod   = 35'(r_w) * $signed({17'd0, RAD_TO_BAM});
        s_hsum    = (s_hprod + (35'sd1 <<< (HSHIFT - 1))) >>> HSHIFT;
        s_heading = r_heading + s_hsum[ANGLE_BITS-1:0];
        s_hwide   = {s_heading, {HSHIFT{1'b0}}};
    end

    always_comb begin
        n_state     = r_state;
        n_wheel     = r_wheel;
        n_cnt       = r_cnt;
        n_vx        = r_vx;
        n_vy        = r_vy;
        n_w         = r_w;
        n_angle     = r_angle;
        n_heading   = r_heading;
        n_rem       = r_rem;
        n_q         = r_q;
        n_amod      = r_amod;
        n_x         = r_x;
        n_y         = r_y;
        n_z         = r_z;
        n_acc       = r_acc;
        n_speed     = r_speed;
        n_ospd      = r_ospd;
        n_hout      = r_hout;
        n_out_valid = r_out_valid;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (i_cfg_we) begin
            n_angle[i_cfg_idx] = i_cfg_data;
        end

        case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_vx    = i_vel_x;
                    n_vy    = i_vel_y;
                    n_w     = i_yaw_rate;
                    n_wheel = '0;
                    n_amod  = s_amod;
                    n_rem   = {s_amod, 6'd0} + DIV_BIAS;
                    n_q     = '0;
                    n_cnt   = CNT_W'(QUO_W - 1);
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                if (r_rem >= s_div_d) begin
                    n_rem = r_rem - s_div_d;
                    n_q   = {r_q[QUO_W-2:0], 1'b1};
                end else begin
                    n_q   = {r_q[QUO_W-2:0], 1'b0};
                end
                if (r_cnt == '0) begin
                    n_state = ST_PREP;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_PREP: begin
                // Quarter-turn pre-rotation keeps the residual angle in CORDIC range.
                if (s_z0 > (ZW'(1) <<< 30)) begin
                    n_x = -s_y0;
                    n_y = s_x0;
                    n_z = s_z0 - (ZW'(1) <<< 30);
                end else if (s_z0 < -(ZW'(1) <<< 30)) begin
                    n_x = s_y0;
                    n_y = -s_x0;
                    n_z = s_z0 + (ZW'(1) <<< 30);
                end else begin
                    n_x = s_x0;
                    n_y = s_y0;
                    n_z = s_z0;
                end
                n_cnt   = '0;
                n_state = ST_ROT;
            end
            ST_ROT: begin
                if (!r_z[ZW-1]) begin
                    n_x = r_x - s_ys;
                    n_y = r_y + s_xs;
                    n_z = r_z - s_atan;
                end else begin
                    n_x = r_x + s_ys;
                    n_y = r_y - s_xs;
                    n_z = r_z + s_atan;
                end
                if (r_cnt == CNT_W'(CORDIC_STEPS - 1)) begin
                    n_cnt   = CNT_W'(GAIN_W - 1);
                    n_acc   = '0;
                    n_state = ST_MUL;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_MUL: begin
                // Most significant constant bit first.
                n_acc = (r_acc <<< 1) + (INV_GAIN[r_cnt] ? ACC_W'(r_x) : '0);
                if (r_cnt == '0) begin
                    n_state = ST_SUM;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            ST_SUM: begin
                n_speed[r_wheel] = s_sat;
                if (r_wheel == WHL_W'(WHEEL_COUNT - 1)) begin
                    n_state = ST_HEAD;
                end else begin
                    n_wheel = s_next_wheel;
                    n_amod  = s_amod;
                    n_rem   = {s_amod, 6'd0} + DIV_BIAS;
                    n_q     = '0;
                    n_cnt   = CNT_W'(QUO_W - 1);
                    n_state = ST_DIV;
                end
            end
            ST_HEAD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_heading   = s_heading;
                    n_hout      = s_hwide[31:16];
                    n_ospd      = r_speed;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_heading   <= '0;
            r_wheel     <= '0;
            r_cnt       <= '0;
            for (int k = 0; k < WHL_MAX; k++) begin
                r_angle[k] <= reset_angle(WHL_W'(k));
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_heading   <= n_heading;
            r_wheel     <= n_wheel;
            r_cnt       <= n_cnt;
            r_angle     <= n_angle;
        end
        r_vx    <= n_vx;
        r_vy    <= n_vy;
        r_w     <= n_w;
        r_rem   <= n_rem;
        r_q     <= n_q;
        r_amod  <= n_amod;
        r_x     <= n_x;
        r_y     <= n_y;
        r_z     <= n_z;
        r_acc   <= n_acc;
        r_speed <= n_speed;
        r_ospd  <= n_ospd;
        r_hout  <= n_hout;
    end

    `FFOWK_ASSERT_NXT(a_head_only, i_clk, i_rst_n, r_state != ST_HEAD, $stable(r_heading), "heading changed outside the update cycle")
    `FFOWK_ASSERT_IMP(a_wheel_range, i_clk, i_rst_n, r_state != ST_IDLE, r_wheel <= WHL_W'(WHEEL_COUNT - 1), "wheel index beyond wheel count")
    `FFOWK_ASSERT_IMP(a_div_cnt, i_clk, i_rst_n, r_state == ST_DIV, r_cnt <= CNT_W'(QUO_W - 1), "divider counter out of range")
    `FFOWK_ASSERT_NXT(a_out_load, i_clk, i_rst_n, r_state == ST_HEAD && (!r_out_valid || i_out_ready), r_out_valid && r_state == ST_IDLE, "result not presented after heading update")

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the field-frame omni-wheel kinematics block.
`timescale 1ns / 1ps
module tb_top;
    import ffowk_pkg::*;

    typedef struct {
        logic signed [IN_W-1:0] vx;
        logic signed [IN_W-1:0] vy;
        logic signed [IN_W-1:0] w;
    } cmd_t;

    typedef struct {
        logic signed [OUT_W-1:0] spd [4];
        logic [HOUT_W-1:0]       hdg;
    } wheel_cmd_t;

    // Register indexes of the wheel mounting angles.
    localparam logic [WHL_W-1:0] REG_WHEEL0 = 2'd0;
    localparam logic [WHL_W-1:0] REG_WHEEL1 = 2'd1;
    localparam logic [WHL_W-1:0] REG_WHEEL2 = 2'd2;
    localparam logic [WHL_W-1:0] REG_WHEEL3 = 2'd3;
    localparam int DRAIN_CYCLES = 200;
    localparam int STEPS = 16;

    // Arctangent steps in 2^32-per-turn units.
    localparam longint ATAN_LUT [16] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [WHL_W-1:0]        i_cfg_idx = '0;
    logic [DEG_W-1:0]        i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic signed [IN_W-1:0]  i_vel_x = '0;
    logic signed [IN_W-1:0]  i_vel_y = '0;
    logic signed [IN_W-1:0]  i_yaw_rate = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [OUT_W-1:0] o_wheel0_speed;
    logic signed [OUT_W-1:0] o_wheel1_speed;
    logic signed [OUT_W-1:0] o_wheel2_speed;
    logic signed [OUT_W-1:0] o_wheel3_speed;
    logic [HOUT_W-1:0]       o_heading_out;

    field_frame_omni_wheel_kinematics dut (.*);

    always #4 i_clk = ~i_clk;

    // Model state: mounting angles and the heading held between commands.
    logic [DEG_W-1:0] mount_deg [4];
    logic [15:0]      heading_bam;

    cmd_t       cmd_queue [$];
    wheel_cmd_t wheel_cmd_queue [$];
    int         send_idle_pct = 0;
    int         recv_idle_pct = 0;
    int         fail_cnt = 0;
    int         beat_out_cnt = 0;
    int         hold_cycles = 0;
    bit         hold_done = 0;

    // Gain-compensated CORDIC rotation of (x, y) by angle t; returns the x component.
    function automatic longint rotate_x_part(longint x, longint y, longint unsigned t);
        longint z, nx, ny;
        z = longint'(t & 64'hFFFF_FFFF);
        if (z >= 64'sd2147483648) z -= 64'sd4294967296;
        if (z > 64'sd1073741824) begin
            nx = -y; ny = x; x = nx; y = ny; z -= 64'sd1073741824;
        end else if (z < -64'sd1073741824) begin
            nx = y; ny = -x; x = nx; y = ny; z += 64'sd1073741824;
        end
        for (int i = 0; i < STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); ny = y + (x >>> i); z -= ATAN_LUT[i];
            end else begin
                nx = x + (y >>> i); ny = y - (x >>> i); z += ATAN_LUT[i];
            end
            x = nx; y = ny;
        end
        return (x * 636751 + (64'sd1 << 19)) >>> 20;
    endfunction

    // Works out the wheel speeds for one command and advances the heading.
    function automatic wheel_cmd_t solve_wheels(cmd_t c);
        wheel_cmd_t r;
        longint vx, vy, w, v, delta;
        longint unsigned a32, h32;
        vx = longint'(c.vx) * 256;
        vy = longint'(c.vy) * 256;
        w  = longint'(c.w);
        h32 = longint'(heading_bam) << 16;
        for (int k = 0; k < 4; k++) begin
            a32 = ((longint'(mount_deg[k]) << 32) + 180) / 360;
            v = rotate_x_part(vx, vy, (a32 - h32) & 64'hFFFF_FFFF) + w * 256;
            v = (v + 128) >>> 8;
            if (v > 131071) v = 131071;
            if (v < -131072) v = -131072;
            r.spd[k] = v[OUT_W-1:0];
        end
        delta = (w * 166886 + (64'sd1 << 15)) >>> 16;
        heading_bam = heading_bam + delta[15:0];
        r.hdg = heading_bam;
        return r;
    endfunction

    // Driver: offers queued commands and predicts each accepted beat.
    always @(posedge i_clk) begin
        cmd_t c;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                c.vx = i_vel_x; c.vy = i_vel_y; c.w = i_yaw_rate;
                wheel_cmd_queue.push_back(solve_wheels(c));
            end
            if (!i_in_valid || o_in_ready) begin
                if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    c = cmd_queue.pop_front();
                    i_vel_x    <= c.vx;
                    i_vel_y    <= c.vy;
                    i_yaw_rate <= c.w;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every output beat against the oldest prediction and drives ready.
    // Once, after a hundred beats, ready is held low for a long stretch so the block
    // backs up and stalls its input.
    always @(posedge i_clk) begin
        wheel_cmd_t e;
        logic signed [OUT_W-1:0] got [4];
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                got[0] = o_wheel0_speed; got[1] = o_wheel1_speed;
                got[2] = o_wheel2_speed; got[3] = o_wheel3_speed;
                beat_out_cnt++;
                if (wheel_cmd_queue.size() == 0) begin
                    $display("%0t: unexpected output beat", $realtime);
                    fail_cnt++;
                end else begin
                    e = wheel_cmd_queue.pop_front();
                    for (int k = 0; k < 4; k++) begin
                        if (got[k] !== e.spd[k]) begin
                            $display("%0t: wheel%0d speed expected %0d actual %0d",
                                     $realtime, k, e.spd[k], got[k]);
                            fail_cnt++;
                        end
                    end
                    if (o_heading_out !== e.hdg) begin
                        $display("%0t: heading expected %0d actual %0d",
                                 $realtime, e.hdg, o_heading_out);
                        fail_cnt++;
                    end
                end
                if (beat_out_cnt == 100 && !hold_done) begin
                    hold_done = 1;
                    hold_cycles = 1500;
                end
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic write_angle(logic [WHL_W-1:0] idx, logic [DEG_W-1:0] deg);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= deg;
        mount_deg[idx] = deg;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_mounts(logic [DEG_W-1:0] a0, logic [DEG_W-1:0] a1,
                              logic [DEG_W-1:0] a2, logic [DEG_W-1:0] a3);
        write_angle(REG_WHEEL0, a0);
        write_angle(REG_WHEEL1, a1);
        write_angle(REG_WHEEL2, a2);
        write_angle(REG_WHEEL3, a3);
    endtask

    // Waits until the pipeline is empty, then gives the block its full latency.
    task automatic wait_drained();
        do @(posedge i_clk);
        while (cmd_queue.size() != 0 || i_in_valid || wheel_cmd_queue.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic signed [IN_W-1:0] rand_field();
        case ($urandom_range(3))
            0: return $signed(16'($urandom_range(1023))) - 16'sd512;
            1: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic queue_cmd(logic signed [IN_W-1:0] vx, logic signed [IN_W-1:0] vy,
                             logic signed [IN_W-1:0] w);
        cmd_t c;
        c.vx = vx; c.vy = vy; c.w = w;
        cmd_queue.push_back(c);
    endtask

    initial begin
        mount_deg[0] = 9'd45;  mount_deg[1] = 9'd135;
        mount_deg[2] = 9'd225; mount_deg[3] = 9'd315;
        heading_bam = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats at the reset angles: zero, field extremes, pure yaw,
        // and turns large enough to drive the heading around the wrap point.
        send_idle_pct = 34; recv_idle_pct = 76;
        queue_cmd(16'sd0, 16'sd0, 16'sd0);
        queue_cmd(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        queue_cmd(16'sh8000, 16'sh8000, 16'sh8000);
        queue_cmd(16'sh7FFF, 16'sh8000, 16'sd0);
        queue_cmd(16'sh8000, 16'sh7FFF, 16'sd0);
        queue_cmd(16'sd4096, 16'sd0, 16'sd0);
        queue_cmd(16'sd0, 16'sd4096, 16'sd0);
        queue_cmd(16'sd0, 16'sd0, 16'sd6434);
        queue_cmd(16'sd4096, 16'sd4096, 16'sd12868);
        queue_cmd(16'sd0, 16'sd0, -16'sd12868);
        queue_cmd(16'sh7FFF, 16'sh7FFF, 16'sh8000);
        queue_cmd(-16'sd1, -16'sd1, -16'sd1);
        queue_cmd(16'sd1, 16'sd1, 16'sd1);
        queue_cmd(16'sh5555, 16'shAAAA, 16'sh5555);
        queue_cmd(16'shAAAA, 16'sh5555, 16'shAAAA);
        wait_drained();

        // Each phase writes a fresh set of angles, including the extremes and
        // values of 360 and above, which wrap around a full turn.
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0: set_mounts(9'd0, 9'd90, 9'd180, 9'd270);
                1: set_mounts(9'd359, 9'd0, 9'd511, 9'd360);
                2: set_mounts(9'd1, 9'd179, 9'd181, 9'd450);
                default: set_mounts(9'($urandom), 9'($urandom_range(359)),
                                    9'($urandom), 9'($urandom_range(359)));
            endcase
            if (ph < 2) begin
                send_idle_pct = 34; recv_idle_pct = 76;
            end else if (ph < 4) begin
                send_idle_pct = 76; recv_idle_pct = 34;
            end else begin
                send_idle_pct = 0; recv_idle_pct = 0;
            end
            for (int n = 0; n < 148; n++) queue_cmd(rand_field(), rand_field(), rand_field());
            // The sender pauses here until every predicted beat has arrived.
            wait_drained();
        end

        set_mounts(9'd45, 9'd135, 9'd225, 9'd315);
        if (fail_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("simulation failed");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/ffowk_pkg.sv
rtl/core/field_frame_omni_wheel_kinematics.sv
bench/tb_top.sv
